// ===== hdl/paged_block_run_allocator_assert.svh =====
// Assertion macros for the paged block-run allocator.
// Taken in by the RTL files that carry concurrent checks.
`ifndef PAGED_BLOCK_RUN_ALLOCATOR_ASSERT_SVH
`define PAGED_BLOCK_RUN_ALLOCATOR_ASSERT_SVH

// Plain property, checked at every clock edge out of reset.
`define PBRA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define PBRA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pbra_pkg.sv =====
// Shared types and constants for the paged block-run allocator.
// Used by pbra_cfg, pbra_scan and paged_block_run_allocator.
package pbra_pkg;

    localparam int PAGE_BYTES          = 4096;
    localparam int PAGE_SHIFT          = 12;
    localparam int BLOCK_BYTES         = 32;
    localparam int BLOCK_SHIFT         = 5;
    localparam int HEADER_BYTES        = 256;
    localparam int DEF_BLOCKS_PER_PAGE = 64;
    localparam int DEF_MAX_PAGES       = 16;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 12;
    localparam int RUN_W   = 7;
    localparam int PCNT_W  = 5;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;

    localparam logic [PCNT_W-1:0] PAGE_COUNT_RESET = PCNT_W'(16);

    // register index, paddr[3:2]
    localparam logic [1:0] REG_PAGE_COUNT = 2'd0;
    localparam logic [1:0] REG_VIRT_BASE  = 2'd1;
    localparam logic [1:0] REG_PHYS_BASE  = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic [PCNT_W-1:0] page_count;
        logic [ADDR_W-1:0] virt_base;
        logic [ADDR_W-1:0] phys_base;
    } cfg_t;

    typedef struct packed {
        logic start;
    } scan_ctrl_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_STEP,
        SCAN_DONE
    } scan_state_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_CHECK,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_ALLOC_MARK,
        ST_ADDR,
        ST_REL_OFFSET,
        ST_REL_CHECK,
        ST_REL_CLEAR,
        ST_OUT
    } alloc_state_t;

endpackage

// ===== hdl/paged_block_run_allocator.sv =====
// Top level of the paged block-run allocator: sequencer, page bitmaps,
// run-length memory, output register. Depends on pbra_pkg, pbra_cfg, pbra_scan.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser func, tdata size_bytes, release_address
//  m_      | out | m_tvalid/m_tready  | tuser granted, tdata virt_address, phys_address
//  apb     | in  | psel/penable       | page_count, virt_base, phys_base
//
// One item at a time; s_tready is high only while idle.
// Allocate: the shift-and scan unit tries page after page, from page 0, until one
// holds a free run of the needed blocks or the last active page is done.
// Release: offset, check and clear steps, with the registered run-length memory read between check and clear.
// After reset a clearing pass zeroes the run-length memory, one word a cycle
// (MEM_DEPTH words, 1024 at the defaults); bitmaps clear at once. A stalled m_ side holds the block.
module paged_block_run_allocator
    import pbra_pkg::*;
#(
    parameter int MAX_PAGES       = DEF_MAX_PAGES,
    parameter int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // size_bytes[11:0], release_address[43:12], zero
    input  logic              s_tuser,   // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // virt_address[31:0], phys_address[63:32]
    output logic              m_tuser,   // granted
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    `include "paged_block_run_allocator_assert.svh"

    localparam int NEED_W    = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int IDX_W     = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1;
    localparam int PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int MEM_DEPTH = MAX_PAGES * BLOCKS_PER_PAGE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int NFULL_W   = SIZE_W + 1;
    localparam int HI_W      = ADDR_W - PAGE_SHIFT;
    localparam int BLK_W     = PAGE_SHIFT - BLOCK_SHIFT;

    typedef logic [BLOCKS_PER_PAGE-1:0] row_t;

    cfg_t               cfg;
    alloc_state_t       state_reg, state_next;

    logic               func_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [IDX_W-1:0]   blk_reg;
    logic [ADDR_W-1:0]  off_reg;
    logic               out_granted_reg;
    logic [ADDR_W-1:0]  out_va_reg;
    logic [ADDR_W-1:0]  out_pa_reg;
    logic [MEM_AW-1:0]  clr_reg;

    row_t               in_use_reg [MAX_PAGES];
    logic [RUN_W-1:0]   run_mem    [MEM_DEPTH];
    logic [RUN_W-1:0]   rd_data_reg;

    scan_ctrl_t         scan_ctrl;
    scan_stat_t         scan_stat;
    logic [IDX_W-1:0]   scan_first;

    logic [CNT_W-1:0]   active;
    logic [NFULL_W-1:0] need_full;
    logic               alloc_bad;
    logic               last_page;
    logic [HI_W-1:0]    page_hi;
    logic [PAGE_SHIFT-1:0] in_page;
    logic [BLK_W-1:0]   blk_idx;
    logic               rel_bad;
    logic               clr_last;
    logic               mem_rd_en;
    logic               mem_wr_en;
    logic [MEM_AW-1:0]  mem_raddr;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [MEM_AW-1:0]  blk_addr;
    logic [RUN_W-1:0]   mem_wdata;
    logic [RUN_W-1:0]   rel_len;
    logic [RUN_W-1:0]   mask_len;
    row_t               ones;
    row_t               mask;
    row_t               cur_row;

    pbra_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbra_scan #(
        .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE),
        .NEED_W          (NEED_W),
        .IDX_W           (IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (scan_ctrl),
        .free_map (~cur_row),
        .need     (need_reg),
        .stat     (scan_stat),
        .first    (scan_first)
    );

    assign cur_row = in_use_reg[page_reg];
    assign active  = (32'(cfg.page_count) > MAX_PAGES) ? CNT_W'(MAX_PAGES)
                                                      : CNT_W'(cfg.page_count);

    assign need_full = (NFULL_W'(size_reg) + NFULL_W'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
    assign alloc_bad = (size_reg == '0) || (32'(size_reg) > PAGE_BYTES)
                    || (32'(need_full) > BLOCKS_PER_PAGE) || (active == '0);
    assign last_page = ((CNT_W'(page_reg) + CNT_W'(1)) == active);

    // release decode from the offset against virt_base
    assign page_hi = off_reg[ADDR_W-1:PAGE_SHIFT];
    assign in_page = off_reg[PAGE_SHIFT-1:0];
    assign blk_idx = BLK_W'((in_page - PAGE_SHIFT'(HEADER_BYTES)) >> BLOCK_SHIFT);
    assign rel_bad = (32'(page_hi) >= 32'(active)) || (32'(in_page) < HEADER_BYTES)
                  || (32'(blk_idx) >= BLOCKS_PER_PAGE);

    assign mem_raddr = MEM_AW'(MEM_AW'(page_hi) * MEM_AW'(BLOCKS_PER_PAGE) + MEM_AW'(blk_idx));
    assign blk_addr  = MEM_AW'(MEM_AW'(page_reg) * MEM_AW'(BLOCKS_PER_PAGE) + MEM_AW'(blk_reg));
    assign mem_waddr = (state_reg == ST_INIT) ? clr_reg : blk_addr;
    assign mem_wdata = (state_reg == ST_ALLOC_MARK) ? RUN_W'(need_reg) : '0;
    assign clr_last  = (clr_reg == MEM_AW'(MEM_DEPTH - 1));

    // only a live run start holds a nonzero word; a release zeroes it again
    assign rel_len  = rd_data_reg;
    assign mask_len = (state_reg == ST_REL_CLEAR) ? rel_len : RUN_W'(need_reg);
    assign ones     = (32'(mask_len) >= BLOCKS_PER_PAGE) ? '1
                    : (row_t'(1) << mask_len) - row_t'(1);
    assign mask     = ones << blk_reg;

    assign m_tdata  = {out_pa_reg, out_va_reg};
    assign m_tuser  = out_granted_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:        if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid) state_next = (s_tuser == FUNC_RELEASE) ? ST_REL_OFFSET
                                                                      : ST_ALLOC_CHECK;
            ST_ALLOC_CHECK: state_next = alloc_bad ? ST_OUT : ST_SCAN_START;
            ST_SCAN_START:  state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT:
                if (scan_stat.done) begin
                    if (scan_stat.hit)  state_next = ST_ALLOC_MARK;
                    else if (last_page) state_next = ST_OUT;
                    else                state_next = ST_SCAN_START;
                end
            ST_ALLOC_MARK:  state_next = ST_ADDR;
            ST_ADDR:        state_next = ST_OUT;
            ST_REL_OFFSET:  state_next = ST_REL_CHECK;
            ST_REL_CHECK:   state_next = rel_bad ? ST_OUT : ST_REL_CLEAR;
            ST_REL_CLEAR:   state_next = ST_OUT;
            ST_OUT:         if (m_tready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        scan_ctrl.start = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        case (state_reg)
            ST_IDLE:       s_tready        = 1'b1;
            ST_SCAN_START: scan_ctrl.start = 1'b1;
            ST_INIT, ST_ALLOC_MARK, ST_REL_CLEAR:
                           mem_wr_en       = 1'b1;
            ST_REL_CHECK:  mem_rd_en       = !rel_bad;
            ST_OUT:        m_tvalid        = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) run_mem[mem_waddr] <= mem_wdata;
        if (mem_rd_en) rd_data_reg <= run_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            clr_reg   <= '0;
            for (int i = 0; i < MAX_PAGES; i++) begin
                in_use_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) clr_reg <= clr_reg + MEM_AW'(1);
            if (state_reg == ST_ALLOC_MARK) begin
                in_use_reg[page_reg] <= in_use_reg[page_reg] | mask;
            end else if (state_reg == ST_REL_CLEAR) begin
                in_use_reg[page_reg] <= in_use_reg[page_reg] & ~mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                func_reg <= s_tuser;
                size_reg <= s_tdata[SIZE_W-1:0];
                addr_reg <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
            end
            ST_ALLOC_CHECK: begin
                need_reg        <= NEED_W'(need_full);
                page_reg        <= '0;
                out_granted_reg <= 1'b0;
                out_va_reg      <= '0;
                out_pa_reg      <= '0;
            end
            ST_SCAN_WAIT:
                if (scan_stat.done) begin
                    if (scan_stat.hit)   blk_reg  <= scan_first;
                    else if (!last_page) page_reg <= page_reg + PAGE_W'(1);
                end
            ST_ALLOC_MARK:
                off_reg <= (ADDR_W'(page_reg) << PAGE_SHIFT) + ADDR_W'(HEADER_BYTES)
                         + (ADDR_W'(blk_reg) << BLOCK_SHIFT);
            ST_ADDR: begin
                out_granted_reg <= 1'b1;
                out_va_reg      <= cfg.virt_base + off_reg;
                out_pa_reg      <= cfg.phys_base + off_reg;
            end
            ST_REL_OFFSET: begin
                off_reg         <= addr_reg - cfg.virt_base;
                out_granted_reg <= 1'b0;
                out_va_reg      <= '0;
                out_pa_reg      <= '0;
            end
            ST_REL_CHECK: begin
                page_reg <= PAGE_W'(page_hi);
                blk_reg  <= IDX_W'(blk_idx);
            end
            ST_REL_CLEAR: out_granted_reg <= (func_reg == FUNC_RELEASE);
            default: ;
        endcase
    end

    `PBRA_ASSERT_IMPL(a_one_item, aclk, aresetn, m_tvalid, !s_tready,
                      "input taken while a result is pending")
    `PBRA_ASSERT_IMPL(a_start_in_use, aclk, aresetn,
                      (state_reg == ST_REL_CLEAR) && (rel_len != '0),
                      in_use_reg[page_reg][blk_reg], "run start on a free block")
    `PBRA_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0,
                      "failed result carries an address")
    `PBRA_ASSERT_IMPL(a_hit_fits, aclk, aresetn, scan_stat.done && scan_stat.hit,
                      (32'(scan_first) + 32'(need_reg)) <= BLOCKS_PER_PAGE,
                      "found run crosses the page end")

endmodule

// ===== hdl/pbra_cfg.sv =====
// APB register file: page count and the two buffer base addresses.
// Depends on pbra_pkg.
module pbra_cfg
    import pbra_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_count <= PAGE_COUNT_RESET;
            cfg_reg.virt_base  <= '0;
            cfg_reg.phys_base  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PAGE_COUNT: cfg_reg.page_count <= pwdata[PCNT_W-1:0];
                REG_VIRT_BASE:  cfg_reg.virt_base  <= pwdata;
                REG_PHYS_BASE:  cfg_reg.phys_base  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAGE_COUNT: prdata = CFG_DW'(cfg_reg.page_count);
            REG_VIRT_BASE:  prdata = cfg_reg.virt_base;
            REG_PHYS_BASE:  prdata = cfg_reg.phys_base;
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== hdl/pbra_scan.sv =====
// Iterative free-run finder for one page bitmap: a shared shift-and unit
// steps through the bits of the run length. Depends on pbra_pkg.
module pbra_scan
    import pbra_pkg::*;
#(
    parameter int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE,
    parameter int NEED_W          = $clog2(BLOCKS_PER_PAGE + 1),
    parameter int IDX_W           = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1
)(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  scan_ctrl_t                 ctrl,
    input  logic [BLOCKS_PER_PAGE-1:0] free_map,
    input  logic [NEED_W-1:0]          need,
    output scan_stat_t                 stat,
    output logic [IDX_W-1:0]           first
);

    localparam int STEP_W = (NEED_W > 1) ? $clog2(NEED_W) : 1;

    typedef logic [BLOCKS_PER_PAGE-1:0] row_t;

    scan_state_t       state_reg, state_next;
    row_t              run_reg;    // starts of free runs of at least 2^step
    row_t              cand_reg;   // starts that fit the bits of need taken so far
    logic [NEED_W-1:0] shift_reg;  // length already covered by cand_reg
    logic [NEED_W-1:0] need_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NEED_W-1:0] pow_amt;
    logic              last_step;

    assign pow_amt   = NEED_W'(1) << step_reg;
    assign last_step = (32'(step_reg) == NEED_W - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SCAN_IDLE: if (ctrl.start) state_next = SCAN_STEP;
            SCAN_STEP: if (last_step)  state_next = SCAN_DONE;
            SCAN_DONE: state_next = SCAN_IDLE;
            default:   state_next = SCAN_IDLE;
        endcase
    end

    always_comb begin
        stat.done = 1'b0;
        stat.hit  = 1'b0;
        case (state_reg)
            SCAN_DONE: begin
                stat.done = 1'b1;
                stat.hit  = |cand_reg;
            end
            default: ;
        endcase
    end

    // lowest candidate start is the first fit
    always_comb begin
        first = '0;
        for (int i = BLOCKS_PER_PAGE - 1; i >= 0; i--) begin
            if (cand_reg[i]) first = IDX_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SCAN_IDLE) step_reg <= '0;
            else if (state_reg == SCAN_STEP) step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SCAN_IDLE && ctrl.start) begin
            run_reg   <= free_map;
            cand_reg  <= '1;
            shift_reg <= '0;
            need_reg  <= need;
        end else if (state_reg == SCAN_STEP) begin
            if (need_reg[step_reg]) begin
                cand_reg  <= cand_reg & (run_reg >> shift_reg);
                shift_reg <= shift_reg + pow_amt;
            end
            run_reg <= run_reg & (run_reg >> pow_amt);
        end
    end

endmodule

// ===== bench/tb_paged_block_run_allocator.sv =====
// Self-checking bench for paged_block_run_allocator: random and directed allocate and
// release items against a behavioral page/block store, with APB setup between phases.
// Depends on pbra_pkg and the paged_block_run_allocator RTL.
`timescale 1ns / 100ps

module tb_paged_block_run_allocator;
    import pbra_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 3;
    localparam int MAX_PAGES       = DEF_MAX_PAGES;
    localparam int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE;
    localparam int STORE_DEPTH     = MAX_PAGES * BLOCKS_PER_PAGE;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_SETTLE      = 40;
    // covers the clearing pass after reset, the longest scan and random stalls,
    // with a large margin on top
    localparam int WATCHDOG_LIMIT  = 8000;

    typedef enum logic {
        REQ_FIXED,
        REQ_LIVE_RELEASE
    } req_kind_t;

    typedef struct {
        req_kind_t         kind;
        logic              func;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;   // byte offset into the run for REQ_LIVE_RELEASE
        bit                drain_first;
    } alloc_req_t;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] virt;
        logic [ADDR_W-1:0] phys;
    } grant_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata  = '0;   // size_bytes[11:0], release_address[43:12], zero
    logic              s_tuser  = 1'b0; // func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;         // virt_address[31:0], phys_address[63:32]
    logic              m_tuser;         // granted
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [CFG_AW-1:0] paddr    = '0;
    logic [CFG_DW-1:0] pwdata   = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // shadow of the block's registers and store
    logic [PCNT_W-1:0] pages_cfg = PAGE_COUNT_RESET;
    logic [ADDR_W-1:0] virt_cfg  = '0;
    logic [ADDR_W-1:0] phys_cfg  = '0;
    bit                in_use_map  [STORE_DEPTH];
    bit [RUN_W-1:0]    run_len_map [STORE_DEPTH];
    logic [ADDR_W-1:0] live_runs[$];   // buffer offsets of runs currently allocated

    alloc_req_t pending_reqs[$];
    grant_t     expected_grants[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         mismatches    = 0;
    int         stall_cycles  = 0;

    paged_block_run_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // First-fit allocate / run release, updates the shadow store.
    function automatic grant_t predict_grant(input logic func, input logic [SIZE_W-1:0] size,
                                             input logic [ADDR_W-1:0] addr);
        grant_t            res;
        int                need, npages, free_run, first, base, idx, len, p, i, j;
        logic [ADDR_W-1:0] off;
        bit                found;
        res    = '0;
        found  = 1'b0;
        npages = (pages_cfg > MAX_PAGES) ? MAX_PAGES : int'(pages_cfg);
        if (func == FUNC_ALLOC) begin
            need = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            if (size != 0 && int'(size) <= PAGE_BYTES && need <= BLOCKS_PER_PAGE) begin
                for (p = 0; p < npages && !found; p++) begin
                    base     = p * BLOCKS_PER_PAGE;
                    free_run = 0;
                    for (i = 0; i < BLOCKS_PER_PAGE && !found; i++) begin
                        free_run = in_use_map[base + i] ? 0 : free_run + 1;
                        if (free_run == need) begin
                            first = i + 1 - need;
                            for (j = 0; j < need; j++) begin
                                in_use_map[base + first + j]  = 1'b1;
                                run_len_map[base + first + j] = '0;
                            end
                            run_len_map[base + first] = RUN_W'(need);
                            off = ADDR_W'(p * PAGE_BYTES + HEADER_BYTES + first * BLOCK_BYTES);
                            res.granted = 1'b1;
                            res.virt    = virt_cfg + off;
                            res.phys    = phys_cfg + off;
                            live_runs.push_back(off);
                            found = 1'b1;
                        end
                    end
                end
            end
        end else begin
            // pages are located relative to virt_base, wrapping mod 2^32
            off = addr - virt_cfg;
            if (off[ADDR_W-1:PAGE_SHIFT] < npages && off[PAGE_SHIFT-1:0] >= HEADER_BYTES) begin
                idx = (int'(off[PAGE_SHIFT-1:0]) - HEADER_BYTES) / BLOCK_BYTES;
                if (idx < BLOCKS_PER_PAGE) begin
                    base = int'(off[ADDR_W-1:PAGE_SHIFT]) * BLOCKS_PER_PAGE;
                    len  = int'(run_len_map[base + idx]);
                    for (i = 0; i < len && idx + i < BLOCKS_PER_PAGE; i++) begin
                        in_use_map[base + idx + i]  = 1'b0;
                        run_len_map[base + idx + i] = '0;
                    end
                    if (len > 0) begin
                        off = ADDR_W'(int'(off[ADDR_W-1:PAGE_SHIFT]) * PAGE_BYTES
                                      + HEADER_BYTES + idx * BLOCK_BYTES);
                        found = 1'b0;
                        for (i = 0; i < live_runs.size() && !found; i++) begin
                            if (live_runs[i] == off) begin
                                live_runs.delete(i);
                                found = 1'b1;
                            end
                        end
                    end
                    res.granted = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input logic func, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr, input bit drain_first);
        alloc_req_t req;
        req.kind        = REQ_FIXED;
        req.func        = func;
        req.size        = size;
        req.addr        = addr;
        req.drain_first = drain_first;
        pending_reqs.push_back(req);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [CFG_DW-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_PAGE_COUNT: pages_cfg = value[PCNT_W-1:0];
            REG_VIRT_BASE:  virt_cfg  = value;
            REG_PHYS_BASE:  phys_cfg  = value;
            default: ;
        endcase
    endtask

    // checked at the falling edge so every update of the rising edge has landed
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0);
    endtask

    task automatic run_phase(input logic [PCNT_W-1:0] pages, input logic [ADDR_W-1:0] vbase,
                             input logic [ADDR_W-1:0] pbase, input int n_items,
                             input int send_pct, input int recv_pct);
        alloc_req_t req;
        int         roll, k;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(REG_PAGE_COUNT, CFG_DW'(pages));
        apb_write(REG_VIRT_BASE, vbase);
        apb_write(REG_PHYS_BASE, pbase);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < n_items; k++) begin
            roll            = $urandom_range(0, 99);
            req.kind        = REQ_FIXED;
            req.size        = SIZE_W'($urandom);
            req.addr        = $urandom;
            req.drain_first = ($urandom_range(0, 99) < 2);
            if (roll < 45) begin
                req.func = FUNC_ALLOC;
                roll     = $urandom_range(0, 99);
                if (roll < 70)      req.size = SIZE_W'($urandom_range(1, 160));
                else if (roll < 90) req.size = SIZE_W'($urandom_range(161, 1024));
                else if (roll < 96) req.size = SIZE_W'($urandom_range(1025, 2048));
                else if (roll < 98) req.size = SIZE_W'($urandom_range(2049, 4095));
                else                req.size = '0;
            end else if (roll < 88) begin
                // release at an offset from the start of a run that is live when the item is presented
                req.kind = REQ_LIVE_RELEASE;
                req.func = FUNC_RELEASE;
                roll     = $urandom_range(0, 99);
                if (roll < 70)      req.addr = '0;
                else if (roll < 85) req.addr = $urandom_range(1, BLOCK_BYTES - 1);
                else                req.addr = BLOCK_BYTES * $urandom_range(1, 3);
            end else begin
                req.func = 1'($urandom_range(0, 1));
            end
            pending_reqs.push_back(req);
        end
    endtask

    always @(posedge aclk) begin : drive_items
        alloc_req_t        nxt;
        logic [ADDR_W-1:0] rel_addr;
        bit                load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_grants.push_back(predict_grant(s_tuser, s_tdata[11:0], s_tdata[43:12]));
            end
            if (!s_tvalid || s_tready) begin
                load = 1'b0;
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    load = !(pending_reqs[0].drain_first && expected_grants.size() != 0);
                end
                if (load) begin
                    nxt = pending_reqs.pop_front();
                    rel_addr = nxt.addr;
                    if (nxt.kind == REQ_LIVE_RELEASE) begin
                        if (live_runs.size() != 0) begin
                            rel_addr = virt_cfg + nxt.addr
                                     + live_runs[$urandom_range(0, live_runs.size() - 1)];
                        end else begin
                            rel_addr = $urandom;
                        end
                    end
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.func;
                    s_tdata  <= {4'b0, rel_addr, nxt.size};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_grants
        grant_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[31:0], '0);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tuser !== want.granted)
                        report_mismatch("granted", ADDR_W'(m_tuser), ADDR_W'(want.granted));
                    if (m_tdata[31:0] !== want.virt)
                        report_mismatch("virt_address", m_tdata[31:0], want.virt);
                    if (m_tdata[63:32] !== want.phys)
                        report_mismatch("phys_address", m_tdata[63:32], want.phys);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_paged_block_run_allocator NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 69;

        // reset config: 16 pages, both bases zero
        queue_item(FUNC_ALLOC, 12'd0, $urandom, 1'b0);       // zero size fails
        queue_item(FUNC_ALLOC, 12'd1, $urandom, 1'b0);       // page 0 block 0
        queue_item(FUNC_ALLOC, 12'd32, $urandom, 1'b0);      // block 1
        queue_item(FUNC_ALLOC, 12'd33, $urandom, 1'b0);      // blocks 2-3
        queue_item(FUNC_ALLOC, 12'd2048, $urandom, 1'b0);    // whole page 1
        queue_item(FUNC_ALLOC, 12'd2049, $urandom, 1'b0);    // more blocks than a page
        queue_item(FUNC_ALLOC, 12'd4095, $urandom, 1'b0);
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_0160, 1'b0); // inside a run
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_0080, 1'b0); // page header
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_0900, 1'b0); // past last block
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0001_0100, 1'b0); // page not in use
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'hFFFF_FFFF, 1'b0);
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_0100, 1'b1); // held until drained
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_0145, 1'b0); // unaligned
        queue_item(FUNC_ALLOC, 12'd64, $urandom, 1'b0);          // refills blocks 2-3
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_1100, 1'b0);
        queue_item(FUNC_RELEASE, SIZE_W'($urandom), 32'h0000_1100, 1'b0); // already free
        queue_item(FUNC_ALLOC, 12'd4064, $urandom, 1'b0);
        queue_item(FUNC_ALLOC, 12'd2016, $urandom, 1'b0);        // 63 blocks, goes to page 1

        run_phase(5'd1, 32'h8000_0000, 32'h0004_0000, 90, 23, 69);
        run_phase(5'd31, 32'hFFFF_F000, 32'hFFFF_8000, 90, 69, 23);
        run_phase(5'd0, $urandom, $urandom, 30, 69, 23);          // nothing is scanned
        run_phase(5'd16, $urandom, $urandom, 110, 0, 0);          // unaligned bases
        run_phase(PCNT_W'($urandom_range(2, 17)), $urandom & 32'hFFFF_F000, $urandom,
                  110, 0, 0);

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_paged_block_run_allocator OK");
        end else begin
            $display("tb_paged_block_run_allocator NOT OK");
        end
        $finish;
    end

endmodule
